FILE: src/word_dictionary_counter_unit_macros.svh
// Assertion macros used by the word dictionary counter controller.
`ifndef WORD_DICTIONARY_COUNTER_UNIT_MACROS_SVH
`define WORD_DICTIONARY_COUNTER_UNIT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define WDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define WDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wdc_pkg.sv
// ----------------------------------------------------------------------------
// wdc_pkg
// Types and constants shared by the word dictionary counter.
// ----------------------------------------------------------------------------
package wdc_pkg;

    localparam int HASH_SLOTS     = 8192;
    localparam int MAX_WORDS      = 4096;
    localparam int MAX_WORD_CHARS = 64;
    localparam int KEEP_CHARS     = MAX_WORD_CHARS - 1;

    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int IDX_W  = $clog2(MAX_WORDS);
    localparam int CH_W   = $clog2(MAX_WORD_CHARS);
    localparam int LEN_W  = $clog2(MAX_WORD_CHARS + 1);
    localparam int DW_W   = $clog2(MAX_WORDS + 1);
    localparam int SE_W   = IDX_W + 1;
    localparam int PRB_W  = $clog2(HASH_SLOTS + 1);
    localparam int TXT_AW = IDX_W + CH_W;

    localparam logic [1:0] ST_EXISTING = 2'd0;
    localparam logic [1:0] ST_NEW      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_CMP,
        S_HIT,
        S_INSERT,
        S_OUT
    } wdc_state_t;

    typedef struct packed {
        logic clr_step;
        logic take_char;
        logic word_start;
        logic hash_step;
        logic probe_read;
        logic probe_next;
        logic cmp_start;
        logic cmp_step;
        logic hit_update;
        logic ins_step;
        logic ins_done;
        logic set_full;
        logic out_load;
    } wdc_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic slot_empty;
        logic entry_ok;
        logic probes_done;
        logic cmp_done;
        logic cmp_fail;
        logic dict_full;
        logic ins_last;
        logic pending_nz;
    } wdc_stat_t;

endpackage

FILE: src/wdc_ram.sv
// ----------------------------------------------------------------------------
// wdc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: src/wdc_datapath.sv
// ----------------------------------------------------------------------------
// wdc_datapath
// Pending word buffer, hash, tables and result registers.
// ----------------------------------------------------------------------------
module wdc_datapath
    import wdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  wdc_cmd_t    cmd,
    input  logic [7:0]  in_byte,
    output wdc_stat_t   stat,
    output logic [11:0] word_index,
    output logic [1:0]  status,
    output logic [31:0] occurrences,
    output logic [31:0] words_seen
);
    // pending word
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [63:0]       hash_reg, hash_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [PRB_W-1:0]  probes_reg, probes_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DW_W-1:0]   dw_reg, dw_next;
    logic [31:0]       total_reg, total_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic              cmp_fail_reg, cmp_fail_next;
    logic [11:0]       oidx_reg, oidx_next;
    logic [1:0]        ost_reg, ost_next;
    logic [31:0]       ocnt_reg, ocnt_next;

    logic [CH_W-1:0]   pc_addr;
    logic              pc_we;
    logic [7:0]        pc_rdata;
    logic              st_we;
    logic [SLOT_W-1:0] st_addr;
    logic [SE_W-1:0]   st_wdata, st_rdata;
    logic              tx_we;
    logic [TXT_AW-1:0] tx_addr;
    logic [7:0]        tx_rdata;
    logic              meta_we;
    logic [LEN_W-1:0]  len_rdata;
    logic [31:0]       cnt_wdata, cnt_rdata;
    logic              cnt_we;
    logic [IDX_W-1:0]  meta_addr;
    logic [LEN_W-1:0]  wr_pos;
    logic [LEN_W-1:0]  pos_prev;
    logic [63:0]       ext;
    logic              cmp_bad;

    assign wr_pos = (plen_reg >= LEN_W'(KEEP_CHARS)) ? LEN_W'(KEEP_CHARS - 1) : plen_reg;
    assign pos_prev = pos_reg - LEN_W'(1);

    // pending char buffer: written on chars, read sequentially during hash,
    // compare and insert sweeps (read address is pos_reg, char 0 at a start)
    assign pc_we   = cmd.take_char;
    assign pc_addr = pc_we ? wr_pos[CH_W-1:0]
                   : ((cmd.word_start || cmd.cmp_start) ? '0 : pos_reg[CH_W-1:0]);

    wdc_ram #(.WIDTH(8), .DEPTH(MAX_WORD_CHARS)) u_pend (
        .aclk(aclk), .we(pc_we), .addr(pc_addr), .wdata(in_byte), .rdata(pc_rdata)
    );

    assign st_we    = cmd.clr_step || cmd.ins_done;
    assign st_addr  = cmd.clr_step ? clr_reg : slot_reg;
    assign st_wdata = cmd.clr_step ? '0 : SE_W'(idx_reg) + SE_W'(1);

    wdc_ram #(.WIDTH(SE_W), .DEPTH(HASH_SLOTS)) u_slot (
        .aclk(aclk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
    );

    // text store: compare reads idx*chars+pos, insert writes pos-1 from pc_rdata
    assign tx_we   = cmd.ins_step || cmd.ins_done;
    assign tx_addr = tx_we ? {idx_reg, pos_prev[CH_W-1:0]}
                           : {idx_reg, pos_reg[CH_W-1:0]};

    wdc_ram #(.WIDTH(8), .DEPTH(MAX_WORDS * MAX_WORD_CHARS)) u_text (
        .aclk(aclk), .we(tx_we), .addr(tx_addr), .wdata(pc_rdata), .rdata(tx_rdata)
    );

    assign meta_we   = cmd.ins_done;
    assign meta_addr = idx_reg;

    wdc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_WORDS)) u_len (
        .aclk(aclk), .we(meta_we), .addr(meta_addr), .wdata(plen_reg), .rdata(len_rdata)
    );

    assign cnt_we    = meta_we || cmd.hit_update;
    assign cnt_wdata = meta_we ? 32'd1
                     : ((cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 32'd1);

    wdc_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_cnt (
        .aclk(aclk), .we(cnt_we), .addr(meta_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
    );

    assign ext = {{56{pc_rdata[7]}}, pc_rdata};

    // from pos 1 on, length and char pos-1 of the stored word are on hand
    assign cmp_bad = (pos_reg != '0) && ((len_rdata != plen_reg) || (pc_rdata != tx_rdata));

    always_comb begin
        plen_next     = plen_reg;
        pos_next      = pos_reg;
        hash_next     = hash_reg;
        slot_next     = slot_reg;
        probes_next   = probes_reg;
        idx_next      = idx_reg;
        dw_next       = dw_reg;
        total_next    = total_reg;
        clr_next      = clr_reg;
        cmp_fail_next = cmp_fail_reg;
        oidx_next     = oidx_reg;
        ost_next      = ost_reg;
        ocnt_next     = ocnt_reg;
        if (cmd.clr_step) begin
            clr_next = clr_reg + SLOT_W'(1);
        end
        if (cmd.take_char) begin
            plen_next = wr_pos + LEN_W'(1);
        end
        if (cmd.word_start) begin
            hash_next  = '0;
            pos_next   = LEN_W'(1);
            total_next = (total_reg == '1) ? total_reg : total_reg + 32'd1;
        end
        if (cmd.hash_step) begin
            // pc_rdata holds char pos-1
            hash_next = hash_reg * 64'd257 + ext;
            pos_next  = pos_reg + LEN_W'(1);
            if (pos_reg == plen_reg) begin
                slot_next   = SLOT_W'((hash_reg * 64'd257 + ext) % HASH_SLOTS);
                probes_next = '0;
            end
        end
        if (cmd.probe_next) begin
            slot_next   = slot_reg + SLOT_W'(1);
            probes_next = probes_reg + PRB_W'(1);
        end
        if (cmd.probe_read) begin
            idx_next = IDX_W'(st_rdata - SE_W'(1));
        end
        if (cmd.cmp_start) begin
            pos_next      = '0;
            cmp_fail_next = 1'b0;
        end
        if (cmd.cmp_step) begin
            pos_next = pos_reg + LEN_W'(1);
            if (cmp_bad) begin
                cmp_fail_next = 1'b1;
            end
        end
        if (cmd.hit_update) begin
            oidx_next = 12'(idx_reg);
            ost_next  = ST_EXISTING;
            ocnt_next = cnt_wdata;
        end
        if (cmd.ins_step) begin
            pos_next = pos_reg + LEN_W'(1);
        end
        if (cmd.ins_done) begin
            dw_next   = dw_reg + DW_W'(1);
            oidx_next = 12'(idx_reg);
            ost_next  = ST_NEW;
            ocnt_next = 32'd1;
        end
        if (cmd.set_full) begin
            oidx_next = '0;
            ost_next  = ST_FULL;
            ocnt_next = '0;
        end
        if (cmd.out_load) begin
            plen_next = '0;
        end
        // insert prepares index and sweep start
        if (cmd.cmp_start && stat.slot_empty) begin
            idx_next = IDX_W'(dw_reg);
            pos_next = LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg  <= '0;
            dw_reg    <= '0;
            total_reg <= '0;
            clr_reg   <= '0;
        end else begin
            plen_reg  <= plen_next;
            dw_reg    <= dw_next;
            total_reg <= total_next;
            clr_reg   <= clr_next;
        end
        pos_reg      <= pos_next;
        hash_reg     <= hash_next;
        slot_reg     <= slot_next;
        probes_reg   <= probes_next;
        idx_reg      <= idx_next;
        cmp_fail_reg <= cmp_fail_next;
        oidx_reg     <= oidx_next;
        ost_reg      <= ost_next;
        ocnt_reg     <= ocnt_next;
    end

    always_comb begin
        stat.clr_done    = (clr_reg == '1);
        stat.hash_done   = (pos_reg == plen_reg);
        stat.slot_empty  = (st_rdata == '0);
        stat.entry_ok    = ((st_rdata - SE_W'(1)) < SE_W'(MAX_WORDS));
        stat.probes_done = (probes_reg == PRB_W'(HASH_SLOTS - 1));
        stat.cmp_done    = (pos_reg == plen_reg);
        stat.cmp_fail    = cmp_fail_reg || cmp_bad;
        stat.dict_full   = (dw_reg == DW_W'(MAX_WORDS));
        stat.ins_last    = (pos_reg == plen_reg);
        stat.pending_nz  = (plen_reg != '0);
    end

    assign word_index  = oidx_reg;
    assign status      = ost_reg;
    assign occurrences = ocnt_reg;
    assign words_seen  = total_reg;
endmodule

FILE: src/wdc_ctrl.sv
// ----------------------------------------------------------------------------
// wdc_ctrl
// Sequencer for clearing, hashing, probing, compare and insert.
// ----------------------------------------------------------------------------
`include "word_dictionary_counter_unit_macros.svh"

module wdc_ctrl
    import wdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       out_free,
    input  wdc_stat_t  stat,
    output wdc_cmd_t   cmd,
    output logic       in_ready,
    output logic       out_push
);
    wdc_state_t state_reg, state_next;
    logic       is_sep, is_skip;

    assign is_skip = (in_byte == CH_CR) || (in_byte == CH_NUL);
    assign is_sep  = (in_byte == CH_SP) || (in_byte == CH_TAB) || (in_byte == CH_LF);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_fire && !is_skip && is_sep && stat.pending_nz) state_next = S_HASH;
            end
            S_HASH: begin
                if (stat.hash_done) state_next = S_PROBE_RD;
            end
            S_PROBE_RD: state_next = S_PROBE_CHK;
            S_PROBE_CHK: begin
                if (stat.slot_empty) begin
                    state_next = stat.dict_full ? S_OUT : S_INSERT;
                end else if (stat.entry_ok) begin
                    state_next = S_CMP;
                end else if (stat.probes_done) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_PROBE_RD;
                end
            end
            S_CMP: begin
                if (stat.cmp_done) begin
                    if (stat.cmp_fail) begin
                        state_next = stat.probes_done ? S_OUT : S_PROBE_RD;
                    end else begin
                        state_next = S_HIT;
                    end
                end
            end
            S_HIT: state_next = S_OUT;
            S_INSERT: begin
                if (stat.ins_last) state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        out_push = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire && !is_skip && !is_sep) cmd.take_char = 1'b1;
                if (in_fire && !is_skip && is_sep && stat.pending_nz) begin
                    cmd.word_start = 1'b1;
                end
            end
            S_HASH: cmd.hash_step = 1'b1;
            S_PROBE_CHK: begin
                cmd.probe_read = 1'b1;
                if (stat.slot_empty && !stat.dict_full) cmd.cmp_start = 1'b1;
                if (stat.slot_empty && stat.dict_full) cmd.set_full = 1'b1;
                if (!stat.slot_empty && stat.entry_ok) cmd.cmp_start = 1'b1;
                if (!stat.slot_empty && !stat.entry_ok) begin
                    if (stat.probes_done) cmd.set_full = 1'b1;
                    else cmd.probe_next = 1'b1;
                end
            end
            S_CMP: begin
                // sweep until the last char is on hand, then decide
                if (!stat.cmp_done) begin
                    cmd.cmp_step = 1'b1;
                end else if (stat.cmp_fail) begin
                    if (stat.probes_done) cmd.set_full = 1'b1;
                    else cmd.probe_next = 1'b1;
                end
            end
            S_HIT: cmd.hit_update = 1'b1;
            S_INSERT: begin
                if (stat.ins_last) cmd.ins_done = 1'b1;
                else cmd.ins_step = 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    out_push     = 1'b1;
                    cmd.out_load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `WDC_ASSERT_IMP(a_ready_idle, in_ready, state_reg == S_IDLE, "ready outside idle")
    `WDC_ASSERT_IMP(a_push_out, out_push, state_reg == S_OUT && out_free, "push without slot")
    `WDC_ASSERT_NEXT(a_word_hash, cmd.word_start, state_reg == S_HASH, "word end did not hash")
endmodule

FILE: src/word_dictionary_counter_unit.sv
// ----------------------------------------------------------------------------
// word_dictionary_counter_unit
// Counts words of a byte stream in a linear-probing hash dictionary.
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, low bit first)
//  s_axis  | in  | text_byte[7:0]
//  m_axis  | out | word_index[11:0] status[13:12] occurrences[45:14] words_seen[77:46]
//
//  A letter or an ignored byte is taken in the idle state. A word end is accepted,
//  the word hashed char by char, each probe reads then checks a slot, each text
//  compare sweeps the word, a new word is stored char by char or a count bumped,
//  and the result loaded; the single-port pending buffer, text store and slot
//  table set this order. After reset a clearing pass over all HASH_SLOTS (8192)
//  slots empties the slot table; no item is accepted meanwhile. A result holds
//  in the output register until taken; input stalls while a word is processed
//  or its result waits for the output register.
// ----------------------------------------------------------------------------
module word_dictionary_counter_unit
    import wdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // word_index, status, occurrences, words_seen, pad
);
    wdc_cmd_t    cmd;
    wdc_stat_t   stat;
    logic        in_fire, out_push, out_free;
    logic        ovalid_reg, ovalid_next;
    logic [77:0] odata_reg, odata_next;
    logic [11:0] widx;
    logic [1:0]  wst;
    logic [31:0] wocc, wseen;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    // accept the new result when the output register is empty or draining
    assign out_free = !ovalid_reg || m_axis_tready;

    wdc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_byte(s_axis_tdata),
        .out_free(out_free), .stat(stat), .cmd(cmd), .in_ready(s_axis_tready),
        .out_push(out_push)
    );

    wdc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_byte(s_axis_tdata), .stat(stat),
        .word_index(widx), .status(wst), .occurrences(wocc), .words_seen(wseen)
    );

    always_comb begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (m_axis_tready) ovalid_next = 1'b0;
        if (out_push) begin
            ovalid_next = 1'b1;
            odata_next  = {wseen, wocc, wst, widx};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
        odata_reg <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, odata_reg};
endmodule

FILE: tb/sv/word_dictionary_counter_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_dictionary_counter_unit_checker
// Watches both streams, tracks the word dictionary and checks every result.
// ----------------------------------------------------------------------------
module word_dictionary_counter_unit_checker
    import wdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    output int          fail_count,
    output int          outstanding,
    output int          n_existing,
    output int          n_new,
    output int          n_full
);

    typedef struct {
        logic [11:0] word_index;
        logic [1:0]  status;
        logic [31:0] occurrences;
        logic [31:0] words_seen;
    } word_result_t;

    word_result_t word_results_q[$];

    // dictionary mirror; slot entry 0 is empty, otherwise index + 1
    int          slot_entry[HASH_SLOTS];
    logic [7:0]  dict_text[MAX_WORDS][MAX_WORD_CHARS];
    int          dict_len[MAX_WORDS];
    logic [31:0] dict_count[MAX_WORDS];
    int          dict_size   = 0;
    logic [31:0] word_total  = '0;
    logic [7:0]  cur_chars[MAX_WORD_CHARS];
    int          cur_len     = 0;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        n_existing  = 0;
        n_new       = 0;
        n_full      = 0;
        foreach (slot_entry[i]) slot_entry[i] = 0;
    end

    function automatic void count_byte(input logic [7:0] c);
        logic [63:0]  h;
        int           slot;
        int           e;
        int           idx;
        bit           found;
        bit           empty_seen;
        bit           same;
        word_result_t r;
        found      = 0;
        empty_seen = 0;
        idx        = 0;
        if (c == CH_CR || c == CH_NUL) return;
        if (c != CH_SP && c != CH_TAB && c != CH_LF) begin
            // past the keep limit the last kept char gets overwritten
            if (cur_len >= KEEP_CHARS) cur_len = KEEP_CHARS - 1;
            cur_chars[cur_len] = c;
            cur_len++;
            return;
        end
        if (cur_len == 0) return;
        if (word_total != 32'hFFFF_FFFF) word_total++;
        h = '0;
        for (int i = 0; i < cur_len; i++)
            h = h * 64'd257 + {{56{cur_chars[i][7]}}, cur_chars[i]};
        slot = int'(h % HASH_SLOTS);
        for (int p = 0; p < HASH_SLOTS; p++) begin
            e = slot_entry[slot];
            if (e == 0) begin
                empty_seen = 1;
                break;
            end
            if (e - 1 < MAX_WORDS && dict_len[e - 1] == cur_len) begin
                same = 1;
                for (int i = 0; i < cur_len; i++)
                    if (dict_text[e - 1][i] != cur_chars[i]) same = 0;
                if (same) begin
                    found = 1;
                    idx   = e - 1;
                    break;
                end
            end
            slot = (slot + 1) % HASH_SLOTS;
        end
        if (found) begin
            if (dict_count[idx] != 32'hFFFF_FFFF) dict_count[idx]++;
            r.occurrences = dict_count[idx];
            r.status      = ST_EXISTING;
        end else if (empty_seen && dict_size < MAX_WORDS) begin
            idx = dict_size;
            for (int i = 0; i < cur_len; i++) dict_text[idx][i] = cur_chars[i];
            dict_len[idx]    = cur_len;
            dict_count[idx]  = 1;
            slot_entry[slot] = idx + 1;
            dict_size++;
            r.occurrences = 1;
            r.status      = ST_NEW;
        end else begin
            idx           = 0;
            r.occurrences = 0;
            r.status      = ST_FULL;
        end
        cur_len      = 0;
        r.word_index = idx[11:0];
        r.words_seen = word_total;
        word_results_q.push_back(r);
    endfunction

    always @(posedge aclk) begin
        word_result_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (word_results_q.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = word_results_q.pop_front();
                    case (want.status)
                        ST_EXISTING: n_existing++;
                        ST_NEW:      n_new++;
                        default:     n_full++;
                    endcase
                    if (m_axis_tdata[11:0] !== want.word_index) begin
                        $error("word_index exp %0d got %0d", want.word_index,
                            m_axis_tdata[11:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[13:12] !== want.status) begin
                        $error("status exp %0d got %0d", want.status, m_axis_tdata[13:12]);
                        fail_count++;
                    end
                    if (m_axis_tdata[45:14] !== want.occurrences) begin
                        $error("occurrences exp %0d got %0d", want.occurrences,
                            m_axis_tdata[45:14]);
                        fail_count++;
                    end
                    if (m_axis_tdata[77:46] !== want.words_seen) begin
                        $error("words_seen exp %0d got %0d", want.words_seen,
                            m_axis_tdata[77:46]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) count_byte(s_axis_tdata);
            outstanding = word_results_q.size();
        end
    end

endmodule

FILE: tb/sv/word_dictionary_counter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_dictionary_counter_unit_tb
// Feeds text bytes with random gaps and back-pressure over a reused vocabulary.
// ----------------------------------------------------------------------------
module word_dictionary_counter_unit_tb;
    import wdc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // text_byte[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // word_index, status, occurrences, words_seen

    int fail_count;
    int outstanding;
    int n_existing;
    int n_new;
    int n_full;
    int bytes_sent    = 0;
    int results_taken = 0;
    bit tx_burst      = 0;
    bit rx_burst      = 0;
    string vocab[$];

    always #2 aclk = ~aclk;

    word_dictionary_counter_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    word_dictionary_counter_unit_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .n_existing    (n_existing),
        .n_new         (n_new),
        .n_full        (n_full)
    );

    // Offer one byte after a random gap; hold it until taken.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(0, 2))
            0:       return CH_SP;
            1:       return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    // Word letter: mostly lowercase, else any byte that is not a separator
    // or an ignored code.
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7) return 8'd97 + 8'($urandom_range(0, 25));
        do c = 8'($urandom_range(1, 255));
        while (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic string make_word(input int len);
        string w;
        w = "";
        repeat (len) w = $sformatf("%s%c", w, pick_char());
        return w;
    endfunction

    // Send a word, sometimes sprinkling dropped bytes between its letters.
    task automatic put_word(input string w, input logic [7:0] sep);
        for (int i = 0; i < w.len(); i++) begin
            if ($urandom_range(0, 19) == 0) put_byte($urandom_range(0, 1) ? CH_CR : CH_NUL);
            put_byte(w[i]);
        end
        put_byte(sep);
    endtask

    // Receiver: random stalls, bursts of always-ready, one long hold-off.
    initial begin
        int stall;
        bit held_off;
        held_off = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!held_off && results_taken >= 30) begin
                // hold off long enough for the block to back up its input
                held_off = 1;
                m_axis_tready <= 1'b0;
                repeat (600) @(negedge aclk);
            end
            if (results_taken % 50 == 0) rx_burst = ($urandom_range(0, 4) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            @(negedge aclk);
            results_taken++;
        end
    end

    // Watchdog: allows the clearing pass and the whole text with its stalls.
    initial begin
        #40_000_000;
        $display("word_dictionary_counter_unit_tb: FAIL");
        $finish;
    end

    initial begin
        string w;
        string long_w;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: single letter, repeats on each separator kind
        put_word("a", CH_SP);
        put_word("a", CH_TAB);
        put_word("a", CH_LF);
        // separators and dropped bytes with nothing pending
        put_byte(CH_SP);
        put_byte(CH_TAB);
        put_byte(CH_NUL);
        put_byte(CH_CR);
        // dropped bytes inside a word collapse it to "bc"
        put_byte(8'd98);
        put_byte(CH_NUL);
        put_byte(8'd99);
        put_byte(CH_CR);
        put_byte(CH_SP);
        put_word("bc", CH_LF);
        // extreme byte values, high bit set to exercise the sign extension
        w = $sformatf("%c%c%c%c", 8'd1, 8'd127, 8'd128, 8'd255);
        put_word(w, CH_SP);
        put_word(w, CH_TAB);
        vocab.push_back("a");
        vocab.push_back("bc");
        vocab.push_back(w);
        // overlong word: only the last letter past the limit survives
        long_w = make_word(70);
        put_word(long_w, CH_SP);
        w = long_w.substr(0, KEEP_CHARS - 2);
        put_word({w, long_w.substr(69, 69)}, CH_LF);
        vocab.push_back(long_w);

        // random text: mostly real words with reuse, some raw noise
        while (bytes_sent < 1500) begin
            tx_burst = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 99) < 85) begin
                if (vocab.size() > 0 && $urandom_range(0, 9) < 6)
                    w = vocab[$urandom_range(0, vocab.size() - 1)];
                else begin
                    w = make_word(($urandom_range(0, 29) == 0) ? $urandom_range(60, 80)
                                                               : $urandom_range(1, 8));
                    vocab.push_back(w);
                end
                put_word(w, pick_sep());
                if ($urandom_range(0, 9) == 0) put_byte(pick_sep());
            end else begin
                put_byte(8'($urandom_range(0, 255)));
            end
        end

        // close with a mix of known words and short new ones
        tx_burst = 0;
        repeat (60) begin
            if ($urandom_range(0, 1))
                put_word(vocab[$urandom_range(0, vocab.size() - 1)], pick_sep());
            else
                put_word(make_word($urandom_range(1, 8)), pick_sep());
        end
        // trailing word without separator yields nothing
        for (int i = 0; i < 4; i++) put_byte(pick_char());
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d text bytes; checked %0d words: %0d new, %0d repeated, %0d full.",
            bytes_sent, n_new + n_existing + n_full, n_new, n_existing, n_full);
        if (fail_count == 0) begin
            $display("word_dictionary_counter_unit_tb: PASS");
        end else begin
            $display("word_dictionary_counter_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/wdc_pkg.sv
src/wdc_ram.sv
src/wdc_datapath.sv
src/wdc_ctrl.sv
src/word_dictionary_counter_unit.sv
tb/sv/word_dictionary_counter_unit_checker.sv
tb/sv/word_dictionary_counter_unit_tb.sv
